// ===== sv/kpte_pkg.sv =====
// ----------------------------------------------------------------------------
// kpte_pkg
// Shared types, key codes and lookup functions for two-key text entry.
// ----------------------------------------------------------------------------
package kpte_pkg;

    localparam int BITMAP_W = 12;
    localparam int KEY_W    = 4;
    localparam int VALUE_W  = 7;

    // key codes: 0..9 digits, then '*' and '#'
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

    // command kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ADDR  = 1'b1;

    // display addresses
    localparam logic [VALUE_W-1:0] HOME_ADDR     = 7'h00;
    localparam logic [VALUE_W-1:0] LINE_TWO      = 7'h40;
    localparam logic [VALUE_W-1:0] LINE_COL_MASK = 7'h0F;
    localparam logic [VALUE_W-1:0] LINE_ONE_END  = 7'h10;
    localparam logic [VALUE_W-1:0] LINE_TWO_END  = 7'h50;

    localparam logic [VALUE_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [VALUE_W-1:0] CHAR_STAR  = 7'h2A;
    localparam logic [VALUE_W-1:0] CHAR_HASH  = 7'h23;
    localparam logic [VALUE_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [VALUE_W-1:0] CASE_DELTA = 7'h20;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } cmd_t;

    // highest set bit wins; bit 0 ('#') only when nothing above is set
    function automatic logic [KEY_W-1:0] encode_key(input logic [BITMAP_W-1:0] bm);
        logic [KEY_W-1:0] k;
        priority casez (bm)
            12'b1???????????: k = 4'd1;
            12'b01??????????: k = 4'd2;
            12'b001?????????: k = 4'd3;
            12'b0001????????: k = 4'd4;
            12'b00001???????: k = 4'd5;
            12'b000001??????: k = 4'd6;
            12'b0000001?????: k = 4'd7;
            12'b00000001????: k = 4'd8;
            12'b000000001???: k = 4'd9;
            12'b0000000001??: k = KEY_STAR;
            12'b00000000001?: k = 4'd0;
            default:          k = KEY_HASH;
        endcase
        return k;
    endfunction

    // upper-case first letter of letter keys 2..9 (index = key - 2)
    function automatic logic [VALUE_W-1:0] letter_base(input logic [2:0] idx);
        logic [VALUE_W-1:0] b;
        unique case (idx)
            3'd0: b = 7'h41; // A
            3'd1: b = 7'h44; // D
            3'd2: b = 7'h47; // G
            3'd3: b = 7'h4A; // J
            3'd4: b = 7'h4D; // M
            3'd5: b = 7'h50; // P
            3'd6: b = 7'h54; // T
            default: b = 7'h57; // W
        endcase
        return b;
    endfunction

    // letters per case: four on keys 7 and 9
    function automatic logic [KEY_W-1:0] letter_count(input logic [2:0] idx);
        return (idx == 3'd5 || idx == 3'd7) ? 4'd4 : 4'd3;
    endfunction

endpackage

// ===== sv/keypad_two_key_text_entry.sv =====
// ----------------------------------------------------------------------------
// keypad_two_key_text_entry
// Pairs keypad presses into character writes and cursor moves for a two-line
// character display, with a two-entry command queue on the output.
// ----------------------------------------------------------------------------
// A press is accepted in any cycle in which the output queue will have room
// for two commands: when it is empty, or holds one command that is being taken
// in that cycle. Decoding and the cursor update finish in the accepting cycle,
// and the commands appear on the output from the next cycle on, one per cycle
// while out_ready is high. A press yields zero, one or two commands; one that
// yields two holds off the next press until its second command is taken;
// while out_ready is high and each press gives at most one command, the block
// takes one press per cycle. An all-zero bitmap is accepted and dropped.
module keypad_two_key_text_entry
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kpte_pkg::BITMAP_W-1:0] key_bitmap,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         cmd_kind,
    output logic [kpte_pkg::VALUE_W-1:0] cmd_value,
    output logic                         last_of_run
);
    import kpte_pkg::*;

    logic               pending_reg, pending_next;
    logic [KEY_W-1:0]   first_key_reg, first_key_next;
    logic [VALUE_W-1:0] cursor_reg, cursor_next;
    cmd_t               queue_reg [2];
    cmd_t               queue_next [2];
    logic [1:0]         count_reg, count_next;

    logic [KEY_W-1:0]   k2;
    logic [2:0]         lidx;
    logic [VALUE_W-1:0] base;
    logic [KEY_W-1:0]   cnt;
    logic               press;
    logic               pop;
    logic               wrote, moved;
    logic [VALUE_W-1:0] ch, new_cur, inc;
    logic [1:0]         n_res;
    cmd_t               r0, r1;
    logic [1:0]         count_pop;

    assign in_ready  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign press     = in_valid && in_ready && (key_bitmap != '0);

    assign cmd_kind    = queue_reg[0].kind;
    assign cmd_value   = queue_reg[0].value;
    assign last_of_run = queue_reg[0].last;

    assign k2   = encode_key(key_bitmap);
    assign lidx = 3'(first_key_reg - 4'd2);
    assign base = letter_base(lidx);
    assign cnt  = letter_count(lidx);
    assign inc  = cursor_reg + 7'd1;

    // pair decode
    always_comb
    begin
        wrote   = 1'b0;
        moved   = 1'b0;
        ch      = '0;
        new_cur = cursor_reg;
        if (first_key_reg >= 4'd2 && first_key_reg <= 4'd9)
        begin
            if (k2 >= 4'd1 && k2 <= cnt)
            begin
                wrote = 1'b1;
                ch    = base + {3'b000, k2} - 7'd1;
            end
            else if (k2 > cnt && k2 <= (cnt << 1) && k2 <= 4'd9)
            begin
                wrote = 1'b1;
                ch    = base + CASE_DELTA + {3'b000, k2} - {3'b000, cnt} - 7'd1;
            end
        end
        else if (first_key_reg == KEY_HASH)
        begin
            wrote = 1'b1;
            if (k2 <= 4'd9)
                ch = CHAR_ZERO + {3'b000, k2};
            else if (k2 == KEY_STAR)
                ch = CHAR_STAR;
            else
                ch = CHAR_HASH;
        end
        else if (first_key_reg == KEY_STAR)
        begin
            unique case (k2)
                4'd1:
                begin
                    moved   = 1'b1;
                    new_cur = HOME_ADDR;
                end
                4'd2:
                begin
                    moved   = 1'b1;
                    new_cur = cursor_reg & LINE_COL_MASK;
                end
                4'd4:
                begin
                    // left is blocked at the start of either line
                    moved   = (cursor_reg != HOME_ADDR) && (cursor_reg != LINE_TWO);
                    new_cur = cursor_reg - 7'd1;
                end
                4'd5:
                begin
                    wrote = 1'b1;
                    ch    = CHAR_SPACE;
                end
                4'd6:
                begin
                    // right is blocked at the last column
                    moved   = (cursor_reg & LINE_COL_MASK) != LINE_COL_MASK;
                    new_cur = inc;
                end
                4'd8:
                begin
                    moved   = 1'b1;
                    new_cur = (cursor_reg & LINE_COL_MASK) | LINE_TWO;
                end
                4'd9:
                begin
                    moved   = 1'b1;
                    new_cur = LINE_TWO;
                end
                default:
                begin
                    moved = 1'b0;
                end
            endcase
        end
    end

    // state update and commands for this press
    always_comb
    begin
        pending_next   = pending_reg;
        first_key_next = first_key_reg;
        cursor_next    = cursor_reg;
        n_res          = 2'd0;
        r0             = '{kind: CMD_WRITE, value: ch, last: 1'b1};
        r1             = '{kind: CMD_ADDR, value: cursor_reg, last: 1'b1};
        if (press)
        begin
            if (!pending_reg)
            begin
                pending_next   = 1'b1;
                first_key_next = k2;
            end
            else
            begin
                pending_next = 1'b0;
                if (wrote)
                begin
                    if (inc == LINE_ONE_END || inc == LINE_TWO_END)
                    begin
                        // end of line: cursor stays, address re-sent
                        n_res       = 2'd2;
                        r0.last     = 1'b0;
                        cursor_next = cursor_reg;
                    end
                    else
                    begin
                        n_res       = 2'd1;
                        cursor_next = inc;
                    end
                end
                else if (moved)
                begin
                    n_res       = 2'd1;
                    r0          = '{kind: CMD_ADDR, value: new_cur, last: 1'b1};
                    cursor_next = new_cur;
                end
            end
        end
    end

    // output queue
    always_comb
    begin
        queue_next[0] = queue_reg[0];
        queue_next[1] = queue_reg[1];
        count_pop     = count_reg;
        if (pop)
        begin
            queue_next[0] = queue_reg[1];
            count_pop     = count_reg - 2'd1;
        end
        if (n_res != 2'd0)
        begin
            if (count_pop == 2'd0)
            begin
                queue_next[0] = r0;
                queue_next[1] = r1;
            end
            else
            begin
                queue_next[1] = r0;
            end
        end
        count_next = count_pop + n_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            first_key_reg <= '0;
            cursor_reg    <= HOME_ADDR;
            count_reg     <= 2'd0;
        end
        else
        begin
            pending_reg   <= pending_next;
            first_key_reg <= first_key_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg[0] <= queue_next[0];
        queue_reg[1] <= queue_next[1];
    end

endmodule

// ===== sv/kpte_checker.sv =====
// ----------------------------------------------------------------------------
// kpte_checker
// Port-level checks for the two-key text entry block, bound to the top level.
// ----------------------------------------------------------------------------
module kpte_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         cmd_kind,
    input logic [kpte_pkg::VALUE_W-1:0] cmd_value,
    input logic                         last_of_run
);
    import kpte_pkg::*;

    // a stalled command holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cmd_kind)
            && $stable(cmd_value) && $stable(last_of_run))
        else $error("output command changed while stalled");

    // the rest of a run is already queued when its first command is taken
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("run broken after non-final command");

    // a set-address always ends its run
    a_addr_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_kind == CMD_ADDR |-> last_of_run)
        else $error("set-address not last of run");

    // addresses stay on the two visible lines
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_kind == CMD_ADDR |-> cmd_value[5:4] == 2'b00)
        else $error("address outside display lines");

endmodule

bind keypad_two_key_text_entry kpte_checker u_kpte_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd_kind    (cmd_kind),
    .cmd_value   (cmd_value),
    .last_of_run (last_of_run)
);
